// File: hdl/http_line_syntax_checker_macros.svh
// Assertion macros shared by the HTTP line syntax checker RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HTTP_LINE_SYNTAX_CHECKER_MACROS_SVH
`define HTTP_LINE_SYNTAX_CHECKER_MACROS_SVH

// Same-cycle implication.
`define HLSC_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HLSC_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hlsc_pkg.sv
// Types, codes and constants of the HTTP line syntax checker.
// Used by hlsc_step and http_line_syntax_checker; depends on nothing.
package hlsc_pkg;

    localparam int LENGTH_WIDTH = 32;
    localparam int TDATA_W      = 48;
    localparam logic [3:0] KEY_LEN = 4'd14;

    typedef enum logic [7:0] {
        SEC_START   = 8'b0000_0001,
        SEC_VERSION = 8'b0000_0010,
        SEC_CODE    = 8'b0000_0100,
        SEC_DESC    = 8'b0000_1000,
        SEC_NAME    = 8'b0001_0000,
        SEC_SPACES  = 8'b0010_0000,
        SEC_VALUE   = 8'b0100_0000,
        SEC_DROP    = 8'b1000_0000
    } t_section;

    typedef enum logic [2:0] {
        ROLE_VERSION = 3'd0,
        ROLE_CODE    = 3'd1,
        ROLE_DESC    = 3'd2,
        ROLE_NAME    = 3'd3,
        ROLE_VALUE   = 3'd4,
        ROLE_SEP     = 3'd5,
        ROLE_DROP    = 3'd6,
        ROLE_END     = 3'd7
    } t_role;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_VERSION    = 4'd1,
        ERR_CODE       = 4'd2,
        ERR_DESC       = 4'd3,
        ERR_NAME_START = 4'd4,
        ERR_NAME_CHAR  = 4'd5,
        ERR_VALUE_CHAR = 4'd6,
        ERR_DUP_LEN    = 4'd7,
        ERR_BAD_LEN    = 4'd8
    } t_err;

    typedef struct packed {
        t_section                  section;
        logic                      line_failed;
        logic [3:0]                match_pos;
        logic                      mismatch;
        logic [LENGTH_WIDTH-1:0]   accum;
        logic                      digits_done;
        logic [LENGTH_WIDTH-1:0]   body_size;
        logic                      length_seen;
    } t_state;

    typedef struct packed {
        logic [7:0]                byte_out;
        t_role                     role;
        t_err                      err;
        logic                      line_ok;
        logic                      length_header;
        logic [LENGTH_WIDTH-1:0]   content_length;
    } t_result;

    function automatic logic [7:0] key_char(input logic [3:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/http_line_syntax_checker.sv
// Path: an accepted word is held in the input register, then in the result register that
// drives the master side. Throughput: one word per cycle unless the master side stalls;
// the per-byte check and the multiply-by-ten accumulate sit in one combinational stage
// between the input register and the result register.
// Reset (i_rst_n low, synchronous): both stages empty, line state at line start,
// stored content length and duplicate flag cleared.
module http_line_syntax_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] char_in
    input  logic                          s_axis_tlast,   // end_of_line
    input  logic                          s_axis_tuser,   // status_line
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] byte_out, [11:8] error_code, [12] line_ok, [13] length_header,
    // [45:14] content_length, [47:46] zero
    output logic [hlsc_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [2:0]                    m_axis_tuser    // byte_role
);
    import hlsc_pkg::*;

    `include "http_line_syntax_checker_macros.svh"

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eol;
    logic       r_in_stat;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    hlsc_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_eol    (r_in_eol),
        .i_stat   (r_in_stat),
        .o_next   (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_eol  <= s_axis_tlast;
            r_in_stat <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.section     <= SEC_START;
            r_state.line_failed <= 1'b0;
            r_state.match_pos   <= 4'd0;
            r_state.mismatch    <= 1'b0;
            r_state.accum       <= '0;
            r_state.digits_done <= 1'b0;
            r_state.body_size   <= '0;
            r_state.length_seen <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.role;
    assign m_axis_tdata  = {2'b00, r_out.content_length, r_out.length_header, r_out.line_ok,
                            r_out.err, r_out.byte_out};

    `HLSC_ASSERT_NOW(a_fail_means_drop, r_state.line_failed, r_state.section == SEC_DROP, "Failed line is not in the drop section.")
    `HLSC_ASSERT_NOW(a_flags_at_line_end, r_out_valid && (r_out.line_ok || r_out.length_header), r_out.role == ROLE_END, "Line flags set on a word that is not a line end.")
    `HLSC_ASSERT_NOW(a_length_positive, r_out_valid && r_out.length_header, r_out.content_length != '0 && r_out.line_ok, "Length header reported with a zero length or a failed line.")
    `HLSC_ASSERT_NEXT(a_result_follows, r_in_valid && !r_out_valid, r_out_valid, "Input word did not reach the result register.")

endmodule

// File: hdl/hlsc_step.sv
// Per-byte classification and state update of the HTTP line syntax checker.
// Pure combinational logic; depends on hlsc_pkg.
module hlsc_step (
    input  hlsc_pkg::t_state  i_state,
    input  logic [7:0]        i_char,
    input  logic              i_eol,
    input  logic              i_stat,
    output hlsc_pkg::t_state  o_next,
    output hlsc_pkg::t_result o_result
);
    import hlsc_pkg::*;

    logic [7:0]                c;
    logic [7:0]                lc;
    logic                      is_digit;
    logic                      is_alpha;
    logic                      is_alnum;
    logic                      is_print;
    logic                      match_hit;
    logic [LENGTH_WIDTH+3:0]   acc_sum;
    logic [LENGTH_WIDTH-1:0]   acc_new;
    t_section                  sec_eff;
    t_state                    nx;
    logic [7:0]                bo;
    t_role                     role;
    t_err                      err;
    logic                      ok;
    logic                      lh;

    assign c        = i_char;
    assign is_digit = (c >= "0") && (c <= "9");
    assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_alnum = is_alpha || is_digit;
    assign is_print = (c >= 8'd32) && (c < 8'd126);
    assign lc       = ((c >= "A") && (c <= "Z")) ? (c | 8'h20) : c;
    assign match_hit = (i_state.match_pos < KEY_LEN) && (lc == key_char(i_state.match_pos));

    // Ten times the accumulator plus the digit; any carry past the length width saturates.
    assign acc_sum = {1'b0, i_state.accum, 3'b000} + {3'b000, i_state.accum, 1'b0}
                   + {{(LENGTH_WIDTH){1'b0}}, c[3:0]};
    assign acc_new = (acc_sum[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0)
                   ? {LENGTH_WIDTH{1'b1}} : acc_sum[LENGTH_WIDTH-1:0];

    always_comb begin
        nx      = i_state;
        bo      = c;
        role    = ROLE_DROP;
        err     = ERR_NONE;
        ok      = 1'b0;
        lh      = 1'b0;
        sec_eff = i_state.section;

        if (i_state.section == SEC_START && i_stat) begin
            nx.body_size   = '0;
            nx.length_seen = 1'b0;
        end

        if (i_eol) begin
            bo   = 8'h00;
            role = ROLE_END;
            if (!i_state.line_failed) begin
                case (i_state.section)
                    SEC_START:   err = i_stat ? ERR_VERSION : ERR_NAME_START;
                    SEC_VERSION: err = ERR_VERSION;
                    SEC_CODE:    err = ERR_CODE;
                    SEC_NAME:    err = ERR_NAME_CHAR;
                    SEC_VALUE: begin
                        if (!i_state.mismatch && i_state.match_pos == KEY_LEN) begin
                            if (i_state.length_seen) begin
                                err = ERR_DUP_LEN;
                            end else if (i_state.accum == '0) begin
                                err            = ERR_BAD_LEN;
                                nx.body_size   = '0;
                                nx.length_seen = 1'b0;
                            end else begin
                                nx.body_size   = i_state.accum;
                                nx.length_seen = 1'b1;
                                lh             = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                ok = (err == ERR_NONE);
            end
            nx.section     = SEC_START;
            nx.line_failed = 1'b0;
            nx.match_pos   = 4'd0;
            nx.mismatch    = 1'b0;
            nx.accum       = '0;
            nx.digits_done = 1'b0;
        end else begin
            if (i_state.section == SEC_START) begin
                if (i_stat) begin
                    sec_eff = SEC_VERSION;
                end else begin
                    bo   = lc;
                    role = ROLE_NAME;
                    if (!is_alpha) begin
                        err = ERR_NAME_START;
                    end else begin
                        if (match_hit) begin
                            nx.match_pos = i_state.match_pos + 4'd1;
                        end else begin
                            nx.mismatch = 1'b1;
                        end
                        nx.section = SEC_NAME;
                    end
                    sec_eff = SEC_DROP;
                end
            end

            case (sec_eff)
                SEC_VERSION: begin
                    role = ROLE_VERSION;
                    if (c == " ") begin
                        role       = ROLE_SEP;
                        nx.section = SEC_CODE;
                    end else if (is_alnum || c == "/" || c == ".") begin
                        nx.section = SEC_VERSION;
                    end else begin
                        err = ERR_VERSION;
                    end
                end
                SEC_CODE: begin
                    if (c == " ") begin
                        role       = ROLE_SEP;
                        nx.section = SEC_DESC;
                    end else begin
                        role = ROLE_CODE;
                        if (!is_digit) begin
                            err = ERR_CODE;
                        end
                    end
                end
                SEC_DESC: begin
                    role = ROLE_DESC;
                    if (!(is_alnum || c == " ")) begin
                        err = ERR_DESC;
                    end
                end
                SEC_NAME: begin
                    if (c == ":") begin
                        role       = ROLE_SEP;
                        nx.section = SEC_SPACES;
                    end else begin
                        bo   = lc;
                        role = ROLE_NAME;
                        if (is_alnum || c == "_" || c == "-") begin
                            if (match_hit) begin
                                nx.match_pos = i_state.match_pos + 4'd1;
                            end else begin
                                nx.mismatch = 1'b1;
                            end
                        end else begin
                            err = ERR_NAME_CHAR;
                        end
                    end
                end
                SEC_SPACES: begin
                    if (c == " ") begin
                        role = ROLE_SEP;
                    end else begin
                        role       = ROLE_VALUE;
                        nx.section = SEC_VALUE;
                        if (!is_print) begin
                            err = ERR_VALUE_CHAR;
                        end else if (c == "-") begin
                            nx.digits_done = 1'b1;
                        end else if (c == "+") begin
                            nx.digits_done = i_state.digits_done;
                        end else if (is_digit) begin
                            nx.accum = acc_new;
                        end else begin
                            nx.digits_done = 1'b1;
                        end
                    end
                end
                SEC_VALUE: begin
                    role = ROLE_VALUE;
                    if (!is_print) begin
                        err = ERR_VALUE_CHAR;
                    end else if (!i_state.digits_done) begin
                        if (is_digit) begin
                            nx.accum = acc_new;
                        end else begin
                            nx.digits_done = 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if (err != ERR_NONE && !i_state.line_failed) begin
                nx.section     = SEC_DROP;
                nx.line_failed = 1'b1;
            end
        end
    end

    assign o_next                  = nx;
    assign o_result.byte_out       = bo;
    assign o_result.role           = role;
    assign o_result.err            = err;
    assign o_result.line_ok        = ok;
    assign o_result.length_header  = lh;
    assign o_result.content_length = nx.body_size;

endmodule

// File: dv/hlsc_line_tracker.sv
// Watches both stream channels of the HTTP line syntax checker, predicts the tag of every
// accepted byte and compares each returned word field by field, in order.
// Depends on hlsc_pkg for the section, role and error codes.
module hlsc_line_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [7:0]                     i_in_data,    // [7:0] char_in
    input  logic                           i_in_last,    // end_of_line
    input  logic                           i_in_user,    // status_line
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    // [7:0] byte_out, [11:8] error_code, [12] line_ok, [13] length_header,
    // [45:14] content_length, [47:46] zero
    input  logic [hlsc_pkg::TDATA_W-1:0]   i_out_data,
    input  logic [2:0]                     i_out_user,   // byte_role
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hlsc_pkg::*;

    typedef struct {
        logic [7:0]              byte_out;
        t_role                   role;
        t_err                    err;
        logic                    line_ok;
        logic                    length_header;
        logic [LENGTH_WIDTH-1:0] content_length;
    } t_byte_tag;

    t_byte_tag               tag_fifo[$];
    int                      mismatches = 0;
    string                   key_text = "content-length";

    t_section                line_sec = SEC_START;
    logic                    line_bad = 1'b0;
    logic [3:0]              key_pos = '0;
    logic                    key_miss = 1'b0;
    logic [LENGTH_WIDTH-1:0] len_accum = '0;
    logic                    len_stop = 1'b0;
    logic [LENGTH_WIDTH-1:0] body_len = '0;
    logic                    len_seen = 1'b0;

    assign o_fail_count = mismatches;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_print(input logic [7:0] c);
        return c >= 8'd32 && c < 8'd126;
    endfunction

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Decimal accumulate that sticks at the all-ones value instead of wrapping.
    function automatic logic [LENGTH_WIDTH-1:0] add_digit(input logic [LENGTH_WIDTH-1:0] acc,
                                                          input logic [7:0] c);
        logic [63:0] acc_w;
        logic [63:0] dig_w;
        logic [63:0] top_w;
        acc_w = 64'(acc);
        dig_w = 64'(c - "0");
        top_w = {{(64 - LENGTH_WIDTH){1'b0}}, {LENGTH_WIDTH{1'b1}}};
        if (acc_w > (top_w - dig_w) / 64'd10) begin
            return top_w[LENGTH_WIDTH-1:0];
        end
        return LENGTH_WIDTH'(acc_w * 64'd10 + dig_w);
    endfunction

    task automatic feed_key(input logic [7:0] lc);
        if (key_pos < KEY_LEN && lc == 8'(key_text[key_pos])) begin
            key_pos++;
        end else begin
            key_miss = 1'b1;
        end
    endtask

    task automatic clear_line();
        line_sec  = SEC_START;
        line_bad  = 1'b0;
        key_pos   = '0;
        key_miss  = 1'b0;
        len_accum = '0;
        len_stop  = 1'b0;
    endtask

    task automatic tag_byte(input logic [7:0] c, input logic eol, input logic stat,
                            output t_byte_tag tag);
        t_section sec;
        tag.byte_out      = c;
        tag.role          = ROLE_DROP;
        tag.err           = ERR_NONE;
        tag.line_ok       = 1'b0;
        tag.length_header = 1'b0;
        if (line_sec == SEC_START && stat) begin
            body_len = '0;
            len_seen = 1'b0;
        end
        if (eol) begin
            tag.byte_out = 8'd0;
            tag.role     = ROLE_END;
            if (!line_bad) begin
                case (line_sec)
                    SEC_START:   tag.err = stat ? ERR_VERSION : ERR_NAME_START;
                    SEC_VERSION: tag.err = ERR_VERSION;
                    SEC_CODE:    tag.err = ERR_CODE;
                    SEC_NAME:    tag.err = ERR_NAME_CHAR;
                    SEC_VALUE: begin
                        if (!key_miss && key_pos == KEY_LEN) begin
                            if (len_seen) begin
                                tag.err = ERR_DUP_LEN;
                            end else if (len_accum == '0) begin
                                tag.err  = ERR_BAD_LEN;
                                body_len = '0;
                                len_seen = 1'b0;
                            end else begin
                                body_len          = len_accum;
                                len_seen          = 1'b1;
                                tag.length_header = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                tag.line_ok = (tag.err == ERR_NONE);
            end
            clear_line();
        end else begin
            sec = line_sec;
            if (line_sec == SEC_START) begin
                if (stat) begin
                    sec = SEC_VERSION;
                end else begin
                    tag.byte_out = lower_ascii(c);
                    tag.role     = ROLE_NAME;
                    if (!is_alpha(c)) begin
                        tag.err  = ERR_NAME_START;
                        line_sec = SEC_DROP;
                        line_bad = 1'b1;
                    end else begin
                        feed_key(lower_ascii(c));
                        line_sec = SEC_NAME;
                    end
                    sec = SEC_DROP;
                end
            end
            case (sec)
                SEC_VERSION: begin
                    if (c == " ") begin
                        tag.role = ROLE_SEP;
                        line_sec = SEC_CODE;
                    end else if (is_alnum(c) || c == "/" || c == ".") begin
                        tag.role = ROLE_VERSION;
                        line_sec = SEC_VERSION;
                    end else begin
                        tag.role = ROLE_VERSION;
                        tag.err  = ERR_VERSION;
                    end
                end
                SEC_CODE: begin
                    if (c == " ") begin
                        tag.role = ROLE_SEP;
                        line_sec = SEC_DESC;
                    end else begin
                        tag.role = ROLE_CODE;
                        if (!is_digit(c)) tag.err = ERR_CODE;
                    end
                end
                SEC_DESC: begin
                    tag.role = ROLE_DESC;
                    if (!(is_alnum(c) || c == " ")) tag.err = ERR_DESC;
                end
                SEC_NAME: begin
                    if (c == ":") begin
                        tag.role = ROLE_SEP;
                        line_sec = SEC_SPACES;
                    end else begin
                        tag.byte_out = lower_ascii(c);
                        tag.role     = ROLE_NAME;
                        if (is_alnum(c) || c == "_" || c == "-") begin
                            feed_key(lower_ascii(c));
                        end else begin
                            tag.err = ERR_NAME_CHAR;
                        end
                    end
                end
                SEC_SPACES: begin
                    if (c == " ") begin
                        tag.role = ROLE_SEP;
                    end else begin
                        tag.role = ROLE_VALUE;
                        line_sec = SEC_VALUE;
                        if (!is_print(c)) begin
                            tag.err = ERR_VALUE_CHAR;
                        end else if (is_digit(c)) begin
                            len_accum = add_digit(len_accum, c);
                        end else if (c != "+") begin
                            len_stop = 1'b1;
                        end
                    end
                end
                SEC_VALUE: begin
                    tag.role = ROLE_VALUE;
                    if (!is_print(c)) begin
                        tag.err = ERR_VALUE_CHAR;
                    end else if (!len_stop) begin
                        if (is_digit(c)) begin
                            len_accum = add_digit(len_accum, c);
                        end else begin
                            len_stop = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (tag.err != ERR_NONE && !line_bad) begin
                line_sec = SEC_DROP;
                line_bad = 1'b1;
            end
        end
        tag.content_length = body_len;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : sample
        t_byte_tag want;
        if (!i_rst_n) begin
            clear_line();
            body_len = '0;
            len_seen = 1'b0;
            tag_fifo.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                tag_byte(i_in_data, i_in_last, i_in_user, want);
                tag_fifo.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (tag_fifo.size() == 0) begin
                    $error("result word 0x%0h arrived with no byte waiting", i_out_data);
                    mismatches++;
                end else begin
                    want = tag_fifo.pop_front();
                    check_field("byte_out", want.byte_out, i_out_data[7:0]);
                    check_field("byte_role", want.role, i_out_user);
                    check_field("error_code", want.err, i_out_data[11:8]);
                    check_field("line_ok", want.line_ok, i_out_data[12]);
                    check_field("length_header", want.length_header, i_out_data[13]);
                    check_field("content_length", want.content_length,
                                i_out_data[14 +: LENGTH_WIDTH]);
                    check_field("pad", '0, i_out_data[TDATA_W-1:14+LENGTH_WIDTH]);
                end
            end
        end
        o_pending <= tag_fifo.size();
    end

endmodule

// File: dv/tb_http_line_syntax_checker.sv
// Top of the HTTP line syntax checker testbench: clock, reset, line stimulus with bursty
// input and a stalling output, a watchdog, and the verdict.
// Depends on hlsc_pkg, the http_line_syntax_checker RTL and hlsc_line_tracker.
module tb_http_line_syntax_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import hlsc_pkg::*;

    typedef logic [7:0] t_bytes[$];

    typedef enum int {
        LN_STATUS,
        LN_HEADER,
        LN_LENGTH,
        LN_NOISE
    } t_line_kind;

    localparam int    RANDOM_WORDS = 580;
    localparam int    HOLD_AT      = 400;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    STALL_LIMIT  = 5000;
    localparam int    TAIL_CYCLES  = 8;
    localparam string DIGITS   = "0123456789";
    localparam string ALPHA    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string VER_SET  = {ALPHA, DIGITS, "/."};
    localparam string DESC_SET = {ALPHA, DIGITS, " "};
    localparam string NAME_SET = {ALPHA, DIGITS, "_-"};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'd0;
    logic                s_axis_tlast = 1'b0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [2:0]          m_axis_tuser;

    int                  fail_count;
    int                  pending;
    int                  words_sent = 0;
    int                  burst_left = 0;
    bit                  hold_done = 1'b0;

    always #5 i_clk = ~i_clk;

    http_line_syntax_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    hlsc_line_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_bytes to_bytes(input string s);
        t_bytes b;
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
        return b;
    endfunction

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic t_bytes make_line(input t_line_kind kind);
        t_bytes b;
        string  key;
        int     r;
        int     n;
        key = "content-length";
        case (kind)
            LN_STATUS: begin
                if ($urandom_range(0, 1)) begin
                    b = to_bytes("HTTP/1.1");
                end else begin
                    repeat ($urandom_range(1, 5)) b.push_back(pick(VER_SET));
                end
                b.push_back(" ");
                repeat ($urandom_range(1, 3)) b.push_back(pick(DIGITS));
                if ($urandom_range(0, 4) != 0) begin
                    b.push_back(" ");
                    repeat ($urandom_range(0, 8)) b.push_back(pick(DESC_SET));
                end
            end
            LN_HEADER: begin
                b.push_back(pick(ALPHA));
                repeat ($urandom_range(0, 7)) b.push_back(pick(NAME_SET));
                b.push_back(":");
                repeat ($urandom_range(0, 2)) b.push_back(" ");
                repeat ($urandom_range(0, 10)) b.push_back(8'($urandom_range(32, 125)));
            end
            LN_LENGTH: begin
                for (int i = 0; i < key.len(); i++) begin
                    if (key[i] >= "a" && key[i] <= "z" && $urandom_range(0, 1)) begin
                        b.push_back(8'(key[i]) - 8'd32);
                    end else begin
                        b.push_back(key[i]);
                    end
                end
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    void'(b.pop_back());
                end else if (r == 1) begin
                    b.push_back(pick(NAME_SET));
                end
                b.push_back(":");
                repeat ($urandom_range(0, 2)) b.push_back(" ");
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    b.push_back("-");
                end else if (r == 1) begin
                    b.push_back("+");
                end
                r = $urandom_range(0, 9);
                n = (r == 0) ? 0 : (r == 1) ? $urandom_range(10, 12) : $urandom_range(1, 4);
                repeat (n) b.push_back(pick(DIGITS));
                repeat ($urandom_range(0, 2)) b.push_back(8'($urandom_range(32, 126)));
            end
            default: begin
                repeat ($urandom_range(0, 6)) b.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        if (kind != LN_NOISE && b.size() > 0 && $urandom_range(0, 4) == 0) begin
            b[$urandom_range(0, b.size() - 1)] = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // The sender runs in bursts; before most bursts, a gap of random length drops tvalid.
    task automatic send_word(input logic [7:0] c, input logic eol, input logic stat);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eol;
        s_axis_tuser  <= stat;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    // Only the first word of a line carries a meaningful status flag.
    task automatic send_line(input t_bytes b, input logic stat);
        foreach (b[i]) begin
            send_word(b[i], 1'b0, (i == 0) ? stat : 1'($urandom_range(0, 1)));
        end
        send_word(8'($urandom_range(0, 255)), 1'b1,
                  (b.size() == 0) ? stat : 1'($urandom_range(0, 1)));
    endtask

    initial begin : out_pattern
        int mode;
        int span;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("FAIL http_line_syntax_checker");
        $finish;
    end

    initial begin : stimulus
        t_bytes     line;
        t_line_kind kind;
        int         stop_at;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_line(to_bytes("HTTP/1.1 200 OK"), 1'b1);
        send_line(to_bytes("Content-Length: 42"), 1'b0);
        send_line(to_bytes("content-length:7"), 1'b0);
        send_line(to_bytes(""), 1'b0);
        send_line(to_bytes(""), 1'b1);
        send_line(to_bytes("H/1"), 1'b1);
        send_line(to_bytes("H 20"), 1'b1);
        send_line(to_bytes("H 2x0 a"), 1'b1);
        send_line(to_bytes("H 2 a!b"), 1'b1);
        send_line(to_bytes("1abc: x"), 1'b0);
        send_line(to_bytes("Ab@c: x"), 1'b0);
        send_line(to_bytes("Host"), 1'b0);
        send_line(to_bytes("X:"), 1'b0);
        line = to_bytes("X: ~");
        send_line(line, 1'b0);
        line = to_bytes("X:  a");
        line.push_back(8'h7f);
        send_line(line, 1'b0);
        line = to_bytes("X: ");
        line.push_back(8'h00);
        send_line(line, 1'b0);
        line = to_bytes("Y");
        line.push_back(8'hff);
        send_line(line, 1'b0);
        send_line(to_bytes("CONTENT-LENGTH: -5"), 1'b0);
        send_line(to_bytes("content-length: +99999999999"), 1'b0);
        send_line(to_bytes("content-length:  "), 1'b0);
        send_line(to_bytes("content-length: 0"), 1'b0);
        send_line(to_bytes("A/1 2 B"), 1'b1);
        send_line(to_bytes("content-length: 12abc"), 1'b0);
        send_line(to_bytes("content-lengthx: 3"), 1'b0);
        send_line(to_bytes("content-lengt: 3"), 1'b0);

        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) != 0) send_line(make_line(LN_STATUS), 1'b1);
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: kind = LN_LENGTH;
                    8, 9:    kind = LN_NOISE;
                    default: kind = LN_HEADER;
                endcase
                send_line(make_line(kind),
                          (kind == LN_NOISE) ? 1'($urandom_range(0, 1)) : 1'b0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS http_line_syntax_checker");
        end else begin
            $display("FAIL http_line_syntax_checker");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/hlsc_pkg.sv
hdl/hlsc_step.sv
hdl/http_line_syntax_checker.sv
dv/hlsc_line_tracker.sv
dv/tb_http_line_syntax_checker.sv
